FILE: design/rsfp_pkg.sv
// ----------------------------------------------------------------------------
// rsfp_pkg
// Shared types, constants and helpers for the radar serial frame parser.
// ----------------------------------------------------------------------------
package rsfp_pkg;

  // Default byte budget of one binary frame after its prefix
  localparam int FRAME_BYTES_DEF = 256;

  // Reset value of the body length limit
  localparam logic [7:0] MAX_BODY_LEN_RST = 8'd240;

  // Frame markers as they appear in the 4-byte window (oldest byte high)
  localparam logic [31:0] PFX_CMD  = 32'hFDFC_FBFA;
  localparam logic [31:0] PFX_DATA = 32'hF4F3_F2F1;
  localparam logic [31:0] SFX_CMD  = 32'h0403_0201;
  localparam logic [31:0] SFX_DATA = 32'hF8F7_F6F5;

  // Largest decimal value on a distance line
  localparam logic [19:0] DEC_LIMIT = 20'd65535;

  // ASCII characters used by the line parser
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_O  = 8'h4F;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_D  = 8'h64;

  // Length of the "distance:" keyword
  localparam logic [3:0] DIST_WORD_LEN = 4'd9;

  // Register map
  localparam logic [0:0] REG_MAX_BODY_LEN = 1'b0;

  // Event kinds on the result channel
  localparam logic [2:0] EV_OFF_LINE  = 3'd0;
  localparam logic [2:0] EV_DIST_LINE = 3'd1;
  localparam logic [2:0] EV_BODY_BYTE = 3'd2;
  localparam logic [2:0] EV_CMD_DONE  = 3'd3;
  localparam logic [2:0] EV_DATA_DONE = 3'd4;

  // Parser states; binary frame states have the top bit set
  typedef enum logic [3:0] {
    PS_IDLE   = 4'd0,
    PS_O      = 4'd1,
    PS_OF     = 4'd2,
    PS_OFF    = 4'd3,
    PS_OFF_T  = 4'd4,
    PS_DIST   = 4'd5,
    PS_NUM    = 4'd6,
    PS_NUM_T  = 4'd7,
    PS_LEN0   = 4'd8,
    PS_LEN1   = 4'd9,
    PS_BODY   = 4'd10,
    PS_SUFFIX = 4'd11
  } parse_state_t;

  // One result item plus its valid flag
  typedef struct packed {
    logic        valid;
    logic [2:0]  event_kind;
    logic [15:0] line_distance;
    logic [7:0]  body_value;
    logic [7:0]  body_index;
    logic [7:0]  body_length;
    logic [15:0] head_command;
    logic [7:0]  head_ack;
    logic        motion;
    logic        still;
    logic [15:0] target_distance;
  } result_t;

  // Character of "distance:" at a given position
  function automatic logic [7:0] dist_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h64; // d
      4'd1:    ch = 8'h69; // i
      4'd2:    ch = 8'h73; // s
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h61; // a
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h63; // c
      4'd7:    ch = 8'h65; // e
      4'd8:    ch = 8'h3A; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // CR LF or LF CR
  function automatic logic term_pair(input logic [7:0] a, input logic [7:0] b);
    return ((a == CH_CR) && (b == CH_LF)) || ((a == CH_LF) && (b == CH_CR));
  endfunction

endpackage

FILE: design/radar_serial_frame_parser_core.sv
// ----------------------------------------------------------------------------
// radar_serial_frame_parser_core
// Receive-stream parser for a presence radar: binary frames and ASCII lines.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_rx_byte) carries one received
//   serial byte per transfer. The result channel (out_valid/out_ready and
//   out_* fields) carries at most one event per byte: OFF line, distance
//   line, body byte with index, or command/data frame completion.
//   Each byte is handled by the step logic and its event lands
//   in the result register, so an event appears in the cycle after its byte is
//   transferred. One byte is taken every cycle while the result register is
//   empty or being drained; the single result register sets this rate.
//   When the receiver stalls with an event held, in_ready drops until the
//   event is transferred; bytes that raise no event still need the result
//   register free to pass.
//   Synchronous active-low reset returns the parser to idle, empties the byte
//   window and the result register, and sets max_body_length to 240.
//   max_body_length sits at address 0 of the APB port and is to be written
//   only while no byte is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module radar_serial_frame_parser_core #(
  parameter int FRAME_BYTES = rsfp_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // events
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [15:0] out_line_distance,
  output logic [7:0]  out_body_value,
  output logic [7:0]  out_body_index,
  output logic [7:0]  out_body_length,
  output logic [15:0] out_head_command,
  output logic [7:0]  out_head_ack,
  output logic        out_motion,
  output logic        out_still,
  output logic [15:0] out_target_distance,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              take;
  logic [7:0]        max_body_length_r;
  rsfp_pkg::result_t step_res;
  rsfp_pkg::result_t held;

  assign take   = in_valid && in_ready;
  assign pready = 1'b1;

  // Register write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_length_r <= rsfp_pkg::MAX_BODY_LEN_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == rsfp_pkg::REG_MAX_BODY_LEN)) begin
      max_body_length_r <= pwdata[7:0];
    end
  end

  // Register read
  always_comb begin
    if (paddr[2] == rsfp_pkg::REG_MAX_BODY_LEN) begin
      prdata = {24'h000000, max_body_length_r};
    end else begin
      prdata = '0;
    end
  end

  rsfp_parser #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (take),
    .rx_byte         (in_rx_byte),
    .max_body_length (max_body_length_r),
    .result          (step_res)
  );

  rsfp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .result    (step_res),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .held      (held)
  );

  // Present the held event
  assign out_event_kind      = held.event_kind;
  assign out_line_distance   = held.line_distance;
  assign out_body_value      = held.body_value;
  assign out_body_index      = held.body_index;
  assign out_body_length     = held.body_length;
  assign out_head_command    = held.head_command;
  assign out_head_ack        = held.head_ack;
  assign out_motion          = held.motion;
  assign out_still           = held.still;
  assign out_target_distance = held.target_distance;

endmodule

FILE: design/rsfp_parser.sv
// ----------------------------------------------------------------------------
// rsfp_parser
// Parse state registers and the one-byte step logic that updates them and
// forms at most one result per received byte.
// ----------------------------------------------------------------------------
module rsfp_parser #(
  parameter int FRAME_BYTES = rsfp_pkg::FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         max_body_length,
  output rsfp_pkg::result_t  result
);

  localparam int FbcW = $clog2(FRAME_BYTES + 1);

  rsfp_pkg::parse_state_t state_r, state_nxt;
  logic [31:0]     win_r, win_nxt;
  logic [2:0]      fill_r, fill_nxt;
  logic [7:0]      prev_r, prev_nxt;
  logic [3:0]      pmi_r, pmi_nxt;
  logic [16:0]     acc_r, acc_nxt;
  logic            seen_r, seen_nxt;
  logic [FbcW-1:0] fbc_r, fbc_nxt;
  logic [7:0]      decl_r, decl_nxt;
  logic [7:0]      bcnt_r, bcnt_nxt;
  logic [7:0]      head_r [4];
  logic [7:0]      head_nxt [4];

  logic        win_full;
  logic [15:0] len16;
  logic [16:0] len_plus;
  logic [19:0] acc_sum;
  logic [1:0]  head_idx;
  logic        is_digit;

  // Step logic for one byte
  always_comb begin
    win_nxt   = {win_r[23:0], rx_byte};
    fill_nxt  = (fill_r < 3'd4) ? fill_r + 3'd1 : fill_r;
    win_full  = (fill_nxt >= 3'd4);
    state_nxt = state_r;
    prev_nxt  = rx_byte;
    pmi_nxt   = pmi_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    fbc_nxt   = fbc_r;
    decl_nxt  = decl_r;
    bcnt_nxt  = bcnt_r;
    head_nxt  = head_r;
    result    = '0;
    len16     = {rx_byte, decl_r};
    len_plus  = {1'b0, len16} + 17'd10;
    head_idx  = fbc_r[1:0] - 2'd2;
    is_digit  = (rx_byte >= rsfp_pkg::CH_ZERO) && (rx_byte <= rsfp_pkg::CH_NINE);
    acc_sum   = (20'(acc_r) << 3) + (20'(acc_r) << 1) + 20'(rx_byte - rsfp_pkg::CH_ZERO);

    if (state_r inside {rsfp_pkg::PS_LEN0, rsfp_pkg::PS_LEN1,
                        rsfp_pkg::PS_BODY, rsfp_pkg::PS_SUFFIX}) begin
      if (fbc_r >= FbcW'(FRAME_BYTES)) begin
        // Drop the frame once the byte budget is spent
        state_nxt = rsfp_pkg::PS_IDLE;
        fbc_nxt   = '0;
        decl_nxt  = '0;
        bcnt_nxt  = '0;
        pmi_nxt   = '0;
        acc_nxt   = '0;
        seen_nxt  = 1'b0;
      end else begin
        // Capture the four bytes after the length field
        if ((fbc_r >= FbcW'(2)) && (fbc_r < FbcW'(6))) begin
          head_nxt[head_idx] = rx_byte;
        end
        fbc_nxt = fbc_r + FbcW'(1);
        case (state_r)
          rsfp_pkg::PS_LEN0: begin
            decl_nxt  = rx_byte;
            state_nxt = rsfp_pkg::PS_LEN1;
          end
          rsfp_pkg::PS_LEN1: begin
            if ((len16 > {8'h00, max_body_length}) ||
                (len_plus > 17'(FRAME_BYTES))) begin
              state_nxt = rsfp_pkg::PS_IDLE;
              fbc_nxt   = '0;
              decl_nxt  = '0;
              bcnt_nxt  = '0;
            end else begin
              bcnt_nxt  = '0;
              state_nxt = (len16 == 16'd0) ? rsfp_pkg::PS_SUFFIX : rsfp_pkg::PS_BODY;
            end
          end
          rsfp_pkg::PS_BODY: begin
            result.valid      = 1'b1;
            result.event_kind = rsfp_pkg::EV_BODY_BYTE;
            result.body_value = rx_byte;
            result.body_index = bcnt_r;
            bcnt_nxt          = bcnt_r + 8'd1;
            if (({1'b0, bcnt_r} + 9'd1) >= {1'b0, decl_r}) begin
              state_nxt = rsfp_pkg::PS_SUFFIX;
            end
          end
          default: begin
            // Search the window for either suffix
            if (win_full && ((win_nxt == rsfp_pkg::SFX_CMD) ||
                             (win_nxt == rsfp_pkg::SFX_DATA))) begin
              result.valid       = 1'b1;
              result.body_length = decl_r;
              if (win_nxt == rsfp_pkg::SFX_CMD) begin
                result.event_kind   = rsfp_pkg::EV_CMD_DONE;
                result.head_command = {head_r[1], head_r[0]};
                result.head_ack     = head_r[2];
              end else begin
                result.event_kind      = rsfp_pkg::EV_DATA_DONE;
                result.motion          = (head_r[0] == 8'd1);
                result.still           = (head_r[0] == 8'd2);
                result.target_distance = {head_r[2], head_r[1]};
              end
              state_nxt = rsfp_pkg::PS_IDLE;
              fbc_nxt   = '0;
              decl_nxt  = '0;
              bcnt_nxt  = '0;
              pmi_nxt   = '0;
              acc_nxt   = '0;
              seen_nxt  = 1'b0;
            end
          end
        endcase
      end
    end else if (win_full && ((win_nxt == rsfp_pkg::PFX_CMD) ||
                              (win_nxt == rsfp_pkg::PFX_DATA))) begin
      // Start a binary frame, abandon any ASCII line
      state_nxt = rsfp_pkg::PS_LEN0;
      fbc_nxt   = '0;
      decl_nxt  = '0;
      bcnt_nxt  = '0;
      pmi_nxt   = '0;
      acc_nxt   = '0;
      seen_nxt  = 1'b0;
    end else begin
      // ASCII line parsing
      case (state_r)
        rsfp_pkg::PS_IDLE: begin
          if (rx_byte == rsfp_pkg::CH_UP_O) begin
            state_nxt = rsfp_pkg::PS_O;
          end else if (rx_byte == rsfp_pkg::CH_LO_D) begin
            state_nxt = rsfp_pkg::PS_DIST;
            pmi_nxt   = 4'd1;
          end
        end
        rsfp_pkg::PS_O: begin
          state_nxt = (rx_byte == rsfp_pkg::CH_UP_F) ? rsfp_pkg::PS_OF : rsfp_pkg::PS_IDLE;
        end
        rsfp_pkg::PS_OF: begin
          state_nxt = (rx_byte == rsfp_pkg::CH_UP_F) ? rsfp_pkg::PS_OFF : rsfp_pkg::PS_IDLE;
        end
        rsfp_pkg::PS_OFF: begin
          state_nxt = ((rx_byte == rsfp_pkg::CH_CR) || (rx_byte == rsfp_pkg::CH_LF)) ?
                      rsfp_pkg::PS_OFF_T : rsfp_pkg::PS_IDLE;
        end
        rsfp_pkg::PS_OFF_T: begin
          if (rsfp_pkg::term_pair(prev_r, rx_byte)) begin
            result.valid      = 1'b1;
            result.event_kind = rsfp_pkg::EV_OFF_LINE;
          end
          state_nxt = rsfp_pkg::PS_IDLE;
        end
        rsfp_pkg::PS_DIST: begin
          if ((pmi_r < rsfp_pkg::DIST_WORD_LEN) && (rx_byte == rsfp_pkg::dist_char(pmi_r))) begin
            pmi_nxt = pmi_r + 4'd1;
            if ((pmi_r + 4'd1) == rsfp_pkg::DIST_WORD_LEN) begin
              state_nxt = rsfp_pkg::PS_NUM;
              acc_nxt   = '0;
              seen_nxt  = 1'b0;
            end
          end else if (pmi_r >= rsfp_pkg::DIST_WORD_LEN) begin
            state_nxt = rsfp_pkg::PS_IDLE;
          end else if (rx_byte == rsfp_pkg::CH_LO_D) begin
            pmi_nxt = 4'd1;
          end else if (rx_byte == rsfp_pkg::CH_UP_O) begin
            state_nxt = rsfp_pkg::PS_O;
          end else begin
            state_nxt = rsfp_pkg::PS_IDLE;
          end
        end
        rsfp_pkg::PS_NUM: begin
          if ((rx_byte == rsfp_pkg::CH_SPACE) || (rx_byte == rsfp_pkg::CH_TAB)) begin
            state_nxt = state_r;
          end else if (is_digit) begin
            seen_nxt = 1'b1;
            if (acc_sum > rsfp_pkg::DEC_LIMIT) begin
              acc_nxt   = 17'h10000;
              state_nxt = rsfp_pkg::PS_IDLE;
            end else begin
              acc_nxt = acc_sum[16:0];
            end
          end else if ((rx_byte == rsfp_pkg::CH_CR) || (rx_byte == rsfp_pkg::CH_LF)) begin
            state_nxt = rsfp_pkg::PS_NUM_T;
          end else begin
            state_nxt = rsfp_pkg::PS_IDLE;
          end
        end
        rsfp_pkg::PS_NUM_T: begin
          if (rsfp_pkg::term_pair(prev_r, rx_byte) && seen_r) begin
            result.valid         = 1'b1;
            result.event_kind    = rsfp_pkg::EV_DIST_LINE;
            result.line_distance = acc_r[15:0];
            result.motion        = 1'b1;
          end
          state_nxt = rsfp_pkg::PS_IDLE;
        end
        default: begin
          state_nxt = rsfp_pkg::PS_IDLE;
        end
      endcase
    end
  end

  // Advance the parse state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rsfp_pkg::PS_IDLE;
      win_r     <= '0;
      fill_r    <= '0;
      prev_r    <= '0;
      pmi_r     <= '0;
      acc_r     <= '0;
      seen_r    <= 1'b0;
      fbc_r     <= '0;
      decl_r    <= '0;
      bcnt_r    <= '0;
      head_r[0] <= '0;
      head_r[1] <= '0;
      head_r[2] <= '0;
      head_r[3] <= '0;
    end else if (take) begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      prev_r  <= prev_nxt;
      pmi_r   <= pmi_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      fbc_r   <= fbc_nxt;
      decl_r  <= decl_nxt;
      bcnt_r  <= bcnt_nxt;
      head_r  <= head_nxt;
    end
  end

`ifndef SYNTHESIS
  // Frame byte count never passes the budget inside a frame
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r[3] |-> (fbc_r <= FbcW'(FRAME_BYTES)))
    else $error("frame byte count past budget");

  // While in the body, fewer body bytes than declared have been seen
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rsfp_pkg::PS_BODY) |-> (bcnt_r < decl_r))
    else $error("body count reached declared length in body state");

  // Window fill saturates at four
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 3'd4)
    else $error("window fill out of range");

  // Every body byte within budget produces a result
  assert property (@(posedge clk) disable iff (!rst_n)
    (take && (state_r == rsfp_pkg::PS_BODY) && (fbc_r < FbcW'(FRAME_BYTES)))
      |-> (result.valid && (result.event_kind == rsfp_pkg::EV_BODY_BYTE)))
    else $error("body byte without result");
`endif

endmodule

FILE: design/rsfp_out_stage.sv
// ----------------------------------------------------------------------------
// rsfp_out_stage
// Result register of the parser: holds one result until the receiver takes
// it and lets a new byte in whenever the register is empty or draining.
// ----------------------------------------------------------------------------
module rsfp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  rsfp_pkg::result_t  result,
  input  logic               out_ready,
  output logic               in_ready,
  output logic               out_valid,
  output rsfp_pkg::result_t  held
);

  logic              valid_r, valid_nxt;
  rsfp_pkg::result_t data_r;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign held      = data_r;

  // Load on a transfer in, clear on a transfer out
  always_comb begin
    if (take) begin
      valid_nxt = result.valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload; refresh only with a new result
  always_ff @(posedge clk) begin
    if (take && result.valid) begin
      data_r <= result;
    end
  end

endmodule
